// ----- sv/raw_bayer_crop_normalize_unit_assert.svh -----
// assertion macros for the raw bayer crop and normalize unit
`ifndef RAW_BAYER_CROP_NORMALIZE_UNIT_ASSERT_SVH
`define RAW_BAYER_CROP_NORMALIZE_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication under reset
`define RBCN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rbcn assertion failed");
// next-cycle implication under reset
`define RBCN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rbcn assertion failed");
`else
`define RBCN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RBCN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/rbcn_pkg.sv -----
// shared types and constants of the raw bayer crop and normalize unit
`default_nettype none
package rbcn_pkg;
	localparam int MAX_WIDTH  = 16384;
	localparam int MAX_HEIGHT = 16384;
	localparam int FRAC_BITS  = 16;
	localparam int SAMPLE_W   = 16;
	localparam int LEVEL_W    = 20;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int LEN_W      = 15;
	localparam int NUM_W      = SAMPLE_W + 1;
	localparam int DIVD_W     = SAMPLE_W + FRAC_BITS + 1;
	localparam int CMP_W      = (DIVD_W > SAMPLE_W + LEVEL_W) ? DIVD_W : SAMPLE_W + LEVEL_W;
	localparam int CNT_W      = $clog2(LEVEL_W);

	// apb register map
	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam logic [2:0] REG_IN_WIDTH     = 3'd0;
	localparam logic [2:0] REG_CROP_LEFT    = 3'd1;
	localparam logic [2:0] REG_CROP_TOP     = 3'd2;
	localparam logic [2:0] REG_OUT_WIDTH    = 3'd3;
	localparam logic [2:0] REG_OUT_HEIGHT   = 3'd4;
	localparam logic [2:0] REG_BLACK_LEVELS = 3'd5;
	localparam logic [2:0] REG_WHITE_LEVEL  = 3'd6;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                frame_start;
	} pix_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic                      clipped;
		logic                      line_end;
		logic                      frame_end;
	} res_t;

	typedef struct packed {
		logic [LEN_W-1:0]      in_width;
		logic [COL_W-1:0]      crop_left;
		logic [ROW_W-1:0]      crop_top;
		logic [LEN_W-1:0]      out_width;
		logic [LEN_W-1:0]      out_height;
		logic [4*SAMPLE_W-1:0] black_levels;
		logic [SAMPLE_W-1:0]   white_level;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic keep;
	} dp_sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} ctrl_state_t;
endpackage
`default_nettype wire

// ----- sv/rbcn_cfg.sv -----
// apb configuration registers
`default_nettype none
module rbcn_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rbcn_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rbcn_pkg::DATA_W-1:0] pwdata,
	output logic      [rbcn_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output rbcn_pkg::cfg_t                   cfg
);
	rbcn_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr_en;

	assign idx    = paddr[rbcn_pkg::ADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_width     <= '0;
			cfg_q.crop_left    <= '0;
			cfg_q.crop_top     <= '0;
			cfg_q.out_width    <= '0;
			cfg_q.out_height   <= '0;
			cfg_q.black_levels <= '0;
			cfg_q.white_level  <= '1;
		end else if (wr_en) begin
			unique case (idx)
				rbcn_pkg::REG_IN_WIDTH:     cfg_q.in_width     <= pwdata[rbcn_pkg::LEN_W-1:0];
				rbcn_pkg::REG_CROP_LEFT:    cfg_q.crop_left    <= pwdata[rbcn_pkg::COL_W-1:0];
				rbcn_pkg::REG_CROP_TOP:     cfg_q.crop_top     <= pwdata[rbcn_pkg::ROW_W-1:0];
				rbcn_pkg::REG_OUT_WIDTH:    cfg_q.out_width    <= pwdata[rbcn_pkg::LEN_W-1:0];
				rbcn_pkg::REG_OUT_HEIGHT:   cfg_q.out_height   <= pwdata[rbcn_pkg::LEN_W-1:0];
				rbcn_pkg::REG_BLACK_LEVELS: cfg_q.black_levels <= pwdata;
				rbcn_pkg::REG_WHITE_LEVEL:  cfg_q.white_level  <= pwdata[rbcn_pkg::SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			rbcn_pkg::REG_IN_WIDTH:     prdata = rbcn_pkg::DATA_W'(cfg_q.in_width);
			rbcn_pkg::REG_CROP_LEFT:    prdata = rbcn_pkg::DATA_W'(cfg_q.crop_left);
			rbcn_pkg::REG_CROP_TOP:     prdata = rbcn_pkg::DATA_W'(cfg_q.crop_top);
			rbcn_pkg::REG_OUT_WIDTH:    prdata = rbcn_pkg::DATA_W'(cfg_q.out_width);
			rbcn_pkg::REG_OUT_HEIGHT:   prdata = rbcn_pkg::DATA_W'(cfg_q.out_height);
			rbcn_pkg::REG_BLACK_LEVELS: prdata = cfg_q.black_levels;
			rbcn_pkg::REG_WHITE_LEVEL:  prdata = rbcn_pkg::DATA_W'(cfg_q.white_level);
			default:                    prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// ----- sv/rbcn_ctrl.sv -----
// controller: sequences pixel load, operand prep, divide steps and result write
`default_nettype none
module rbcn_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pix_valid,
	output logic                       pix_stall,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	input  wire rbcn_pkg::dp_sts_t     sts,
	output rbcn_pkg::ctrl_cmd_t        cmd
);
	rbcn_pkg::ctrl_state_t       state_q, state_nxt;
	logic [rbcn_pkg::CNT_W-1:0]  cnt_q;
	logic                        out_valid_q;
	logic                        accept;
	logic                        out_free;
	logic                        last_step;

	assign accept    = pix_valid && (state_q == rbcn_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || !res_stall;
	assign last_step = cnt_q == rbcn_pkg::CNT_W'(rbcn_pkg::LEVEL_W - 1);
	assign res_valid = out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rbcn_pkg::ST_IDLE: if (accept && sts.keep) state_nxt = rbcn_pkg::ST_PREP;
			rbcn_pkg::ST_PREP: state_nxt = rbcn_pkg::ST_DIV;
			rbcn_pkg::ST_DIV:  if (last_step) state_nxt = rbcn_pkg::ST_DONE;
			rbcn_pkg::ST_DONE: if (out_free) state_nxt = rbcn_pkg::ST_IDLE;
			default:           state_nxt = rbcn_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		pix_stall  = state_q != rbcn_pkg::ST_IDLE;
		cmd.load   = accept;
		cmd.prep   = state_q == rbcn_pkg::ST_PREP;
		cmd.step   = state_q == rbcn_pkg::ST_DIV;
		cmd.finish = (state_q == rbcn_pkg::ST_DONE) && out_free;
	end

	// state, divide step count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rbcn_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == rbcn_pkg::ST_DIV) begin
				cnt_q <= cnt_q + rbcn_pkg::CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/rbcn_dp.sv -----
// datapath: position counters, crop test, operand prep, radix-2 divider, result register
`default_nettype none
module rbcn_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rbcn_pkg::cfg_t      cfg,
	input  wire rbcn_pkg::pix_t      pix,
	input  wire rbcn_pkg::ctrl_cmd_t cmd,
	output rbcn_pkg::dp_sts_t        sts,
	output rbcn_pkg::res_t           res
);
	localparam int SW = rbcn_pkg::SAMPLE_W;
	localparam int LW = rbcn_pkg::LEVEL_W;
	localparam int NW = rbcn_pkg::NUM_W;
	localparam int DW = rbcn_pkg::DIVD_W;
	localparam int CW = rbcn_pkg::CMP_W;
	localparam int XW = rbcn_pkg::COL_W;
	localparam int YW = rbcn_pkg::ROW_W;
	localparam int LNW = rbcn_pkg::LEN_W;
	localparam logic [LW-1:0] LVL_MAX = {1'b0, {(LW-1){1'b1}}};
	localparam logic [LW-1:0] LVL_MIN = {1'b1, {(LW-1){1'b0}}};

	// position counters
	logic [XW-1:0] col_q, col_eff;
	logic [YW-1:0] row_q, row_eff;
	logic [LNW-1:0] line_len;
	logic           wrap;

	// load stage
	logic [1:0]          chan;
	logic [SW-1:0]       blk;
	logic signed [NW-1:0] num_s1, div_s1;
	logic                last_col_s1, last_row_s1;

	// prep stage
	logic [SW-1:0] nm_c, dm_c;
	logic [DW-1:0] dividend_c;
	logic          ovf_c;
	logic [SW-1:0] dm_s2;
	logic          neg_s2, ovf_s2, dzero_s2, numpos_s2, numneg_s2;
	logic          last_col_s2, last_row_s2;

	// divider
	logic [SW-1:0] rem_q;
	logic [LW-1:0] nlo_q, quo_q;
	logic [SW:0]   trial;
	logic          ge;

	// result
	logic [LW-1:0] lvl_c;
	logic          clip_c;
	rbcn_pkg::res_t res_q;

	assign col_eff = pix.frame_start ? '0 : col_q;
	assign row_eff = pix.frame_start ? '0 : row_q;
	assign line_len = (cfg.in_width == '0 || cfg.in_width > LNW'(rbcn_pkg::MAX_WIDTH))
		? LNW'(rbcn_pkg::MAX_WIDTH) : cfg.in_width;
	assign wrap = (LNW'(col_eff) + LNW'(1)) >= line_len;

	// crop window test
	assign sts.keep = (col_eff >= cfg.crop_left)
		&& (LNW'(col_eff - cfg.crop_left) < cfg.out_width)
		&& (row_eff >= cfg.crop_top)
		&& (LNW'(row_eff - cfg.crop_top) < cfg.out_height);

	assign chan = {row_eff[0], col_eff[0]};
	assign blk  = cfg.black_levels[chan*SW +: SW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			if (wrap) begin
				col_q <= '0;
				if (row_eff < YW'(rbcn_pkg::MAX_HEIGHT - 1)) begin
					row_q <= row_eff + YW'(1);
				end else begin
					row_q <= row_eff;
				end
			end else begin
				col_q <= col_eff + XW'(1);
				row_q <= row_eff;
			end
		end
	end

	// numerator, divisor and window edge flags
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_s1      <= $signed({1'b0, pix.sample}) - $signed({1'b0, blk});
			div_s1      <= $signed({1'b0, cfg.white_level}) - $signed({1'b0, blk});
			last_col_s1 <= LNW'(col_eff - cfg.crop_left) == cfg.out_width - LNW'(1);
			last_row_s1 <= LNW'(row_eff - cfg.crop_top) == cfg.out_height - LNW'(1);
		end
	end

	// magnitudes, rounded dividend and quotient range check
	assign nm_c = num_s1[NW-1] ? SW'(-num_s1) : num_s1[SW-1:0];
	assign dm_c = div_s1[NW-1] ? SW'(-div_s1) : div_s1[SW-1:0];
	assign dividend_c = {1'b0, nm_c, rbcn_pkg::FRAC_BITS'(0)} + DW'(dm_c >> 1);
	assign ovf_c = CW'(dividend_c) >= CW'({dm_c, LW'(0)});

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			dm_s2       <= dm_c;
			neg_s2      <= num_s1[NW-1] ^ div_s1[NW-1];
			ovf_s2      <= ovf_c;
			dzero_s2    <= div_s1 == '0;
			numpos_s2   <= !num_s1[NW-1] && (num_s1 != '0);
			numneg_s2   <= num_s1[NW-1];
			last_col_s2 <= last_col_s1;
			last_row_s2 <= last_row_s1;
		end
	end

	// restoring divide, one quotient bit per cycle
	assign trial = {rem_q, nlo_q[LW-1]};
	assign ge    = trial >= {1'b0, dm_s2};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_q <= SW'(dividend_c >> LW);
			nlo_q <= dividend_c[LW-1:0];
			quo_q <= '0;
		end else if (cmd.step) begin
			rem_q <= ge ? SW'(trial - {1'b0, dm_s2}) : trial[SW-1:0];
			nlo_q <= {nlo_q[LW-2:0], 1'b0};
			quo_q <= {quo_q[LW-2:0], ge};
		end
	end

	// sign, saturation and zero divisor handling
	always_comb begin
		clip_c = 1'b0;
		lvl_c  = quo_q;
		if (dzero_s2) begin
			clip_c = 1'b1;
			lvl_c  = numpos_s2 ? LVL_MAX : (numneg_s2 ? LVL_MIN : '0);
		end else if (ovf_s2) begin
			clip_c = 1'b1;
			lvl_c  = neg_s2 ? LVL_MIN : LVL_MAX;
		end else if (neg_s2) begin
			if (quo_q > LVL_MIN) begin
				clip_c = 1'b1;
				lvl_c  = LVL_MIN;
			end else begin
				lvl_c = ~quo_q + LW'(1);
			end
		end else if (quo_q > LVL_MAX) begin
			clip_c = 1'b1;
			lvl_c  = LVL_MAX;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.level     <= $signed(lvl_c);
			res_q.clipped   <= clip_c;
			res_q.line_end  <= last_col_s2;
			res_q.frame_end <= last_col_s2 && last_row_s2;
		end
	end

	assign res = res_q;
endmodule
`default_nettype wire

// ----- sv/raw_bayer_crop_normalize_unit.sv -----
// top level of the raw bayer crop and normalize unit
// A pixel outside the crop window is taken without stalling the input and yields nothing.
// A pixel inside the window is loaded, then its operand magnitudes and the rounded dividend
// are formed, then the restoring divider produces one quotient bit per cycle, and last the
// result is saturated and written to the result register. The input is stalled while the
// pixel is prepared, divided and written, and longer while an earlier result still waits
// at a stalled output. The result register lets the next pixel be taken while a finished
// result still waits at the output. Channel is chosen by the parity of the absolute input
// row and column; registers sit on an APB port at 8*i.
`default_nettype none
`include "raw_bayer_crop_normalize_unit_assert.svh"
module raw_bayer_crop_normalize_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rbcn_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rbcn_pkg::DATA_W-1:0] pwdata,
	output logic      [rbcn_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	input  wire logic                        pix_valid,
	output logic                             pix_stall,
	input  wire rbcn_pkg::pix_t              pix,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output rbcn_pkg::res_t                   res
);
	rbcn_pkg::cfg_t      cfg;
	rbcn_pkg::ctrl_cmd_t cmd;
	rbcn_pkg::dp_sts_t   sts;

	// configuration registers
	rbcn_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// controller
	rbcn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	rbcn_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pix    (pix),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	// checks
	`RBCN_ASSERT_NXT(a_drop_no_stall, clk, arst_n, pix_valid && !pix_stall && !sts.keep, !pix_stall)
	`RBCN_ASSERT_NXT(a_keep_starts, clk, arst_n, pix_valid && !pix_stall && sts.keep, cmd.prep)
	`RBCN_ASSERT_NXT(a_finish_valid, clk, arst_n, cmd.finish, res_valid)
	`RBCN_ASSERT_IMP(a_frame_on_line, clk, arst_n, res_valid && res.frame_end, res.line_end)
endmodule
`default_nettype wire

// ----- dv/raw_bayer_crop_normalize_unit_tb.sv -----
// self-checking testbench of the raw bayer crop and normalize unit
`default_nettype none
module raw_bayer_crop_normalize_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     IDLE_PCT    = 26;
	localparam int     ITEMS       = 1950;
	localparam int     TAIL_CYCLES = 40;
	localparam longint RUN_LIMIT   = 64'd10_000_000;
	localparam int     LEVEL_TOP   = (1 << (rbcn_pkg::LEVEL_W - 1)) - 1;
	localparam int     LEVEL_FLOOR = 1 << (rbcn_pkg::LEVEL_W - 1);

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        psel      = 1'b0;
	logic                        penable   = 1'b0;
	logic                        pwrite    = 1'b0;
	logic [rbcn_pkg::ADDR_W-1:0] paddr     = '0;
	logic [rbcn_pkg::DATA_W-1:0] pwdata    = '0;
	logic [rbcn_pkg::DATA_W-1:0] prdata;
	logic                        pready;
	logic                        pix_valid = 1'b0;
	logic                        pix_stall;
	rbcn_pkg::pix_t              pix_req   = '0;
	logic                        res_valid;
	logic                        res_stall = 1'b0;
	rbcn_pkg::res_t              res_out;

	raw_bayer_crop_normalize_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix_req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res_out)
	);

	// pixel stream waiting to be sent and normalized levels still due
	rbcn_pkg::pix_t raw_stream[$];
	rbcn_pkg::res_t expected_levels[$];

	// mirror of the register file and the raster position
	rbcn_pkg::cfg_t regs;
	int             chan_div[4];
	int unsigned    next_col;
	int unsigned    next_row;

	int idle_pct = IDLE_PCT;
	int errors;
	int pixels_pushed;
	int pixels_taken;
	int kept_pixels;
	int levels_checked;
	int clipped_seen;
	int frame_ends_seen;
	int settings_used;

	initial begin
		forever #5 clk = ~clk;
	end

	// register write as seen by the unit, divisors follow white and black levels
	function automatic void load_register(input logic [2:0] idx, input logic [63:0] value);
		case (idx)
			rbcn_pkg::REG_IN_WIDTH:     regs.in_width     = value[rbcn_pkg::LEN_W-1:0];
			rbcn_pkg::REG_CROP_LEFT:    regs.crop_left    = value[rbcn_pkg::COL_W-1:0];
			rbcn_pkg::REG_CROP_TOP:     regs.crop_top     = value[rbcn_pkg::ROW_W-1:0];
			rbcn_pkg::REG_OUT_WIDTH:    regs.out_width    = value[rbcn_pkg::LEN_W-1:0];
			rbcn_pkg::REG_OUT_HEIGHT:   regs.out_height   = value[rbcn_pkg::LEN_W-1:0];
			rbcn_pkg::REG_BLACK_LEVELS: regs.black_levels = value;
			rbcn_pkg::REG_WHITE_LEVEL:  regs.white_level  = value[rbcn_pkg::SAMPLE_W-1:0];
			default: ;
		endcase
		for (int c = 0; c < 4; c++)
			chan_div[c] = int'(regs.white_level) - int'(regs.black_levels[16*c +: 16]);
	endfunction

	// advance the raster position and normalize the pixel if it lies in the window
	function automatic bit normalize_pixel(input rbcn_pkg::pix_t p, output rbcn_pkg::res_t r);
		int unsigned line_len;
		int unsigned row;
		int unsigned col;
		int unsigned ch;
		int          blk;
		int          num;
		int          dv;
		int          lvl;
		longint unsigned nm;
		longint unsigned dm;
		longint unsigned q;
		bit          neg;
		bit          clip;
		line_len = (regs.in_width == 0 || regs.in_width > rbcn_pkg::MAX_WIDTH)
			? rbcn_pkg::MAX_WIDTH : regs.in_width;
		if (p.frame_start) begin
			next_col = 0;
			next_row = 0;
		end
		row = next_row;
		col = next_col;
		if (col + 1 >= line_len) begin
			next_col = 0;
			if (next_row < rbcn_pkg::MAX_HEIGHT - 1)
				next_row++;
		end else begin
			next_col = col + 1;
		end
		r = '0;
		if (!(col >= regs.crop_left && col - regs.crop_left < regs.out_width &&
				row >= regs.crop_top && row - regs.crop_top < regs.out_height))
			return 1'b0;

		ch   = {row[0], col[0]};
		blk  = int'(regs.black_levels[16*ch +: 16]);
		num  = int'(p.sample) - blk;
		dv   = chan_div[ch];
		clip = 1'b0;
		if (dv == 0) begin
			// black equals white: sign of the numerator only
			clip = 1'b1;
			lvl  = (num > 0) ? LEVEL_TOP : ((num < 0) ? -LEVEL_FLOOR : 0);
		end else begin
			nm  = (num < 0) ? longint'(-num) : longint'(num);
			dm  = (dv < 0) ? longint'(-dv) : longint'(dv);
			neg = (num < 0) != (dv < 0);
			q   = ((nm << rbcn_pkg::FRAC_BITS) + dm / 2) / dm;
			if (neg) begin
				if (q > LEVEL_FLOOR) begin
					q    = LEVEL_FLOOR;
					clip = 1'b1;
				end
				lvl = -int'(q);
			end else begin
				if (q > LEVEL_TOP) begin
					q    = LEVEL_TOP;
					clip = 1'b1;
				end
				lvl = int'(q);
			end
		end
		r.level     = lvl[rbcn_pkg::LEVEL_W-1:0];
		r.clipped   = clip;
		r.line_end  = (col - regs.crop_left) == regs.out_width - 1;
		r.frame_end = r.line_end && ((row - regs.crop_top) == regs.out_height - 1);
		return 1'b1;
	endfunction

	function automatic void take_pixel(input rbcn_pkg::pix_t p);
		rbcn_pkg::res_t want;
		pixels_taken++;
		if (normalize_pixel(p, want)) begin
			expected_levels.push_back(want);
			kept_pixels++;
		end
	endfunction

	task automatic check_result(input rbcn_pkg::res_t got);
		rbcn_pkg::res_t want;
		levels_checked++;
		if (expected_levels.size() == 0) begin
			if (errors < 40)
				$display("%0t: unexpected result, expected none, got level %0d clipped %0b",
					$time, got.level, got.clipped);
			errors++;
			return;
		end
		want = expected_levels.pop_front();
		clipped_seen    += got.clipped;
		frame_ends_seen += got.frame_end;
		if (got.level !== want.level || got.clipped !== want.clipped ||
				got.line_end !== want.line_end || got.frame_end !== want.frame_end) begin
			if (errors < 40) begin
				if (got.level !== want.level)
					$display("%0t: level expected %0d got %0d", $time, want.level, got.level);
				if (got.clipped !== want.clipped)
					$display("%0t: clipped expected %0b got %0b", $time, want.clipped, got.clipped);
				if (got.line_end !== want.line_end)
					$display("%0t: line_end expected %0b got %0b", $time, want.line_end,
						got.line_end);
				if (got.frame_end !== want.frame_end)
					$display("%0t: frame_end expected %0b got %0b", $time, want.frame_end,
						got.frame_end);
			end
			errors++;
		end
	endtask

	// pixel request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_valid && !pix_stall)
				take_pixel(pix_req);
			if (!pix_valid || !pix_stall) begin
				if (raw_stream.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					pix_req   <= raw_stream.pop_front();
					pix_valid <= 1'b1;
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				check_result(res_out);
			res_stall <= ($urandom_range(0, 99) < idle_pct);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		load_register(idx, value);
	endtask

	task automatic setup_window(input int in_w, input int left, input int top, input int ow,
			input int oh, input logic [63:0] blacks, input int white);
		write_reg(rbcn_pkg::REG_IN_WIDTH, 64'(in_w));
		write_reg(rbcn_pkg::REG_CROP_LEFT, 64'(left));
		write_reg(rbcn_pkg::REG_CROP_TOP, 64'(top));
		write_reg(rbcn_pkg::REG_OUT_WIDTH, 64'(ow));
		write_reg(rbcn_pkg::REG_OUT_HEIGHT, 64'(oh));
		write_reg(rbcn_pkg::REG_BLACK_LEVELS, blacks);
		write_reg(rbcn_pkg::REG_WHITE_LEVEL, 64'(white));
		settings_used++;
		@(negedge clk);
	endtask

	function automatic void push_pixel(input int s, input bit st);
		rbcn_pkg::pix_t p;
		p.sample      = s[rbcn_pkg::SAMPLE_W-1:0];
		p.frame_start = st;
		raw_stream.push_back(p);
		pixels_pushed++;
	endfunction

	// wait until every pixel is taken and every result is back, then let the divider drain
	task automatic settle();
		do
			@(negedge clk);
		while (raw_stream.size() != 0 || pix_valid || expected_levels.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		#(RUN_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// stimulus
	initial begin
		int          w;
		int          left;
		int          top;
		int          ow;
		int          oh;
		int          wp;
		int          b;
		int          s;
		int          mn;
		int          mx;
		int          lo;
		int          hi;
		int          rows;
		int          frames;
		int          phase;
		bit          st;
		logic [63:0] bl;

		regs       = '0;
		regs.white_level = 16'hFFFF;
		next_col   = 0;
		next_row   = 0;
		for (int c = 0; c < 4; c++)
			chan_div[c] = 65535;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// channel cases: overflow, zero divisor, black above white, below black
		setup_window(4, 0, 0, 4, 2, {16'd990, 16'd1500, 16'd1000, 16'd0}, 1000);
		push_pixel(65535, 1'b1);
		push_pixel(1000, 1'b0);
		push_pixel(0, 1'b0);
		push_pixel(0, 1'b0);
		push_pixel(0, 1'b0);
		push_pixel(65535, 1'b0);
		push_pixel(1000, 1'b0);
		push_pixel(985, 1'b0);
		for (int k = 0; k < 4; k++)
			push_pixel($urandom_range(0, 65535), 1'b0);
		// restart at the start of a line below the window
		push_pixel(12345, 1'b1);
		push_pixel(65535, 1'b0);
		settle();

		// odd window origin, full scale white, zero black
		setup_window(3, 1, 1, 2, 1, 64'd0, 65535);
		push_pixel(65535, 1'b1);
		push_pixel(0, 1'b0);
		push_pixel(1, 1'b0);
		push_pixel(40000, 1'b0);
		push_pixel(65535, 1'b0);
		push_pixel(0, 1'b0);
		push_pixel(77, 1'b0);
		push_pixel(65535, 1'b0);
		settle();

		// zero line length acts as the maximum, black above white everywhere
		setup_window(0, 5, 0, 16384, 16384, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		for (int k = 0; k < 24; k++)
			push_pixel($urandom_range(0, 65535), k == 0);
		settle();

		// oversized line length, zero divisor on every channel
		setup_window(32767, 3, 0, 6, 1, 64'd0, 0);
		for (int k = 0; k < 24; k++)
			push_pixel((k % 3 == 0) ? 0 : $urandom_range(0, 65535), k == 0);
		settle();

		// random windows and levels, small frames
		phase = 0;
		while (pixels_pushed < ITEMS) begin
			w    = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
			left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 1);
			top  = $urandom_range(0, 2);
			ow   = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, w + 1);
			oh   = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4);
			case ($urandom_range(0, 19))
				0:       wp = 0;
				1, 2:    wp = 65535;
				default: wp = $urandom_range(256, 65535);
			endcase
			mn = wp;
			mx = wp;
			for (int c = 0; c < 4; c++) begin
				case ($urandom_range(0, 19))
					0, 1:    b = wp;
					2, 3:    b = $urandom_range(wp, 65535);
					4:       b = $urandom_range(0, 65535);
					default: b = $urandom_range(0, wp / 4);
				endcase
				bl[16*c +: 16] = b[15:0];
				mn = (b < mn) ? b : mn;
				mx = (b > mx) ? b : mx;
			end
			lo = (mn > 256) ? mn - 256 : 0;
			hi = (mx < 65279) ? mx + 256 : 65535;
			setup_window(w, left, top, ow, oh, bl, wp);
			// a long stretch of phases runs with both sides at full rate
			idle_pct = (phase >= 8 && phase < 14) ? 0 : IDLE_PCT;
			frames   = $urandom_range(2, 5);
			for (int f = 0; f < frames; f++) begin
				rows = top + oh + $urandom_range(0, 1);
				for (int k = 0; k < w * rows; k++) begin
					case ($urandom_range(0, 19))
						0:       s = $urandom_range(0, 65535);
						1:       s = 0;
						2:       s = 65535;
						default: s = $urandom_range(lo, hi);
					endcase
					// mostly clean frames, some missing or stray frame starts
					st = (k == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
					push_pixel(s, st);
				end
			end
			settle();
			phase++;
		end
		idle_pct = IDLE_PCT;

		settle();
		$display("tb: %0d pixels sent over %0d window settings, %0d inside the window",
			pixels_taken, settings_used, kept_pixels);
		$display("tb: %0d results checked, %0d clipped and %0d frame ends among them",
			levels_checked, clipped_seen, frame_ends_seen);
		if (errors == 0 && expected_levels.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
